// ===== src/nclex_pkg.sv =====
package nclex_pkg;

	// outcome codes
	localparam logic [2:0] OC_RUN   = 3'd0;
	localparam logic [2:0] OC_INT   = 3'd1;
	localparam logic [2:0] OC_FLOAT = 3'd2;
	localparam logic [2:0] OC_NONE  = 3'd3;
	localparam logic [2:0] OC_NEG   = 3'd4;
	localparam logic [2:0] OC_ERR   = 3'd5;

	// error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_ZERO_DIGIT = 3'd1;
	localparam logic [2:0] ERR_NO_FRAC    = 3'd2;
	localparam logic [2:0] ERR_BAD_EXP    = 3'd3;
	localparam logic [2:0] ERR_NO_EXP_DIG = 3'd4;

	// characters of interest
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_EXP_U = 8'h45;
	localparam logic [7:0] CH_EXP_L = 8'h65;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;

	typedef struct packed {
		logic       taken;
		logic       finished;
		logic [2:0] outcome;
		logic [2:0] error_kind;
		logic       hb_valid;
		logic [7:0] hb_char;
		logic [7:0] length;
	} nclex_result_t;

endpackage

// ===== src/numeric_constant_lexer_core.sv =====
// Numeric constant scanner: one character word in, one result word out.
// Latency: the result of a character is presented the cycle after it is accepted.
// Throughput: one character per cycle while the output is not stalled; the scanner state updates in the accept cycle.
// in_ready is high whenever the output register is empty or being drained.
// Reset (arst_n low, asynchronous): start state, floating flag and length cleared,
// output register empty.
module numeric_constant_lexer_core import nclex_pkg::*; #(
	parameter int unsigned MAX_LENGTH = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       taken,
	output logic       finished,
	output logic [2:0] outcome,
	output logic [2:0] error_kind,
	output logic       handed_back_valid,
	output logic [7:0] handed_back_char,
	output logic [7:0] constant_length
);

	localparam int unsigned CapInt = (MAX_LENGTH > 255) ? 255 : MAX_LENGTH;
	localparam logic [7:0]  LenCap = CapInt[7:0];

	logic          accept;
	nclex_result_t result;
	nclex_result_t out_q;
	logic          out_valid_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	nclex_fsm #(
		.LEN_CAP(LenCap)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.char_in (char_in),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

	assign out_valid         = out_valid_q;
	assign taken             = out_q.taken;
	assign finished          = out_q.finished;
	assign outcome           = out_q.outcome;
	assign error_kind        = out_q.error_kind;
	assign handed_back_valid = out_q.hb_valid;
	assign handed_back_char  = out_q.hb_char;
	assign constant_length   = out_q.length;

endmodule

// ===== src/nclex_fsm.sv =====
module nclex_fsm import nclex_pkg::*; #(
	parameter logic [7:0] LEN_CAP = 8'd255
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic [7:0]    char_in,
	output nclex_result_t result
);

	typedef enum logic [2:0] {
		ST_START,
		ST_MINUS,
		ST_ZERO,
		ST_POINT,
		ST_MANT,
		ST_EXP,
		ST_ESIGN,
		ST_EDIG
	} scan_state_t;

	scan_state_t state_q, state_d;
	logic        float_q, float_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  last_q;

	logic        is_dig, is_alpha;
	logic        take, fin, clr_len, hand_back, set_float;
	logic [2:0]  oc, err;
	logic [2:0]  end_oc;
	logic [7:0]  len_base, len;

	assign is_dig   = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign is_alpha = ((char_in >= CH_UC_A) && (char_in <= CH_UC_Z)) ||
	                  ((char_in >= CH_LC_A) && (char_in <= CH_LC_Z));
	assign end_oc   = float_q ? OC_FLOAT : OC_INT;

	always_comb begin
		take      = 1'b0;
		fin       = 1'b0;
		clr_len   = 1'b0;
		hand_back = 1'b0;
		set_float = 1'b0;
		oc        = OC_RUN;
		err       = ERR_NONE;
		state_d   = state_q;
		case (state_q)
			ST_START: begin
				if (char_in == CH_ZERO) begin
					take = 1'b1; state_d = ST_ZERO;
				end else if (char_in == CH_MINUS) begin
					take = 1'b1; state_d = ST_MINUS;
				end else if (char_in == CH_POINT) begin
					take = 1'b1; set_float = 1'b1; state_d = ST_POINT;
				end else if (is_dig) begin
					take = 1'b1; state_d = ST_MANT;
				end else begin
					fin = 1'b1; oc = OC_NONE;
				end
			end
			ST_MINUS: begin
				if (char_in == CH_POINT) begin
					take = 1'b1; set_float = 1'b1; state_d = ST_POINT;
				end else if (is_dig) begin
					take = 1'b1; state_d = ST_MANT;
				end else begin
					// lone minus is the negate operator, nothing counted
					fin = 1'b1; oc = OC_NEG; clr_len = 1'b1;
				end
			end
			ST_ZERO: begin
				if (char_in == CH_POINT) begin
					take = 1'b1; set_float = 1'b1; state_d = ST_MANT;
				end else if (is_dig) begin
					fin = 1'b1; oc = OC_ERR; err = ERR_ZERO_DIGIT;
				end else begin
					fin = 1'b1; oc = end_oc;
				end
			end
			ST_POINT: begin
				if (is_dig) begin
					take = 1'b1; state_d = ST_MANT;
				end else begin
					fin = 1'b1; oc = OC_ERR; err = ERR_NO_FRAC;
				end
			end
			ST_MANT: begin
				if (char_in == CH_POINT && !float_q) begin
					take = 1'b1; set_float = 1'b1;
				end else if (char_in == CH_EXP_U || char_in == CH_EXP_L) begin
					take = 1'b1; state_d = ST_EXP;
				end else if (is_dig) begin
					take = 1'b1;
				end else begin
					fin = 1'b1; oc = end_oc;
				end
			end
			ST_EXP: begin
				if (char_in == CH_MINUS || char_in == CH_PLUS) begin
					take = 1'b1; set_float = 1'b1; state_d = ST_ESIGN;
				end else if (is_dig) begin
					take = 1'b1; set_float = 1'b1; state_d = ST_EDIG;
				end else if (is_alpha) begin
					// E was the start of a word: give the letter back
					fin = 1'b1; hand_back = 1'b1; oc = end_oc;
				end else begin
					fin = 1'b1; oc = OC_ERR; err = ERR_BAD_EXP;
				end
			end
			ST_ESIGN: begin
				if (is_dig) begin
					take = 1'b1; state_d = ST_EDIG;
				end else begin
					fin = 1'b1; oc = OC_ERR; err = ERR_NO_EXP_DIG;
				end
			end
			ST_EDIG: begin
				if (is_dig) begin
					take = 1'b1;
				end else begin
					fin = 1'b1; oc = end_oc;
				end
			end
			default: begin
				fin = 1'b1; oc = OC_NONE;
			end
		endcase
		if (fin) begin
			state_d = ST_START;
		end
	end

	always_comb begin
		len_base = count_q;
		if (clr_len) begin
			len_base = 8'd0;
		end else if (hand_back && count_q != 8'd0) begin
			len_base = count_q - 8'd1;
		end
		len = len_base;
		if (take && len_base < LEN_CAP) begin
			len = len_base + 8'd1;
		end
		count_d = fin ? 8'd0 : len;
		float_d = fin ? 1'b0 : (float_q | set_float);
	end

	always_comb begin
		result.taken      = take;
		result.finished   = fin;
		result.outcome    = oc;
		result.error_kind = err;
		result.hb_valid   = hand_back;
		result.hb_char    = hand_back ? last_q : 8'd0;
		result.length     = len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			float_q <= 1'b0;
			count_q <= 8'd0;
			last_q  <= 8'd0;
		end else if (advance) begin
			state_q <= state_d;
			float_q <= float_d;
			count_q <= count_d;
			if (take) begin
				last_q <= char_in;
			end
		end
	end

endmodule

// ===== src/nclex_checker.sv =====
module nclex_checker import nclex_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       taken,
	input logic       finished,
	input logic [2:0] outcome,
	input logic [2:0] error_kind,
	input logic       handed_back_valid,
	input logic [7:0] handed_back_char,
	input logic [7:0] constant_length
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(outcome) &&
		$stable(taken) && $stable(constant_length))
		else $error("result word changed while stalled");

	// every character either joins the constant or ends it
	a_take_or_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (taken != finished))
		else $error("taken and finished both set or both clear");

	a_outcome_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (finished == (outcome != OC_RUN)))
		else $error("outcome does not match finished");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_kind != ERR_NONE) |-> (outcome == OC_ERR))
		else $error("error kind without error outcome");

	a_hand_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && handed_back_valid |-> finished &&
		(handed_back_char == CH_EXP_U || handed_back_char == CH_EXP_L))
		else $error("bad handed back letter");

endmodule

bind numeric_constant_lexer_core nclex_checker u_nclex_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.taken             (taken),
	.finished          (finished),
	.outcome           (outcome),
	.error_kind        (error_kind),
	.handed_back_valid (handed_back_valid),
	.handed_back_char  (handed_back_char),
	.constant_length   (constant_length)
);
